// ===== hdl/oidl_pkg.sv =====
// ordered id list engine: shared types and codes
// opcodes, status codes, cell command kinds and register indexes
// no dependencies; the design files that use it refer to it by scoped names, the testbench imports it
`default_nettype none

package oidl_pkg;

    // request and result field types
    typedef logic [3:0]  t_opcode;
    typedef logic [3:0]  t_item_id;
    typedef logic [4:0]  t_first_pos;
    typedef logic [3:0]  t_second_pos;
    typedef logic [1:0]  t_status;
    typedef logic [3:0]  t_entry;
    typedef logic [15:0] t_id_mask;
    typedef logic [4:0]  t_length;
    typedef logic [4:0]  t_ids_cfg;
    typedef logic [1:0]  t_cell_kind;

    // opcodes
    localparam t_opcode OP_CLEAR     = 4'd0;
    localparam t_opcode OP_LOAD_ASC  = 4'd1;
    localparam t_opcode OP_LOAD_DESC = 4'd2;
    localparam t_opcode OP_INSERT    = 4'd3;
    localparam t_opcode OP_MOVE      = 4'd4;
    localparam t_opcode OP_EXCHANGE  = 4'd5;
    localparam t_opcode OP_FILL_TAIL = 4'd6;
    localparam t_opcode OP_FILL_HEAD = 4'd7;
    localparam t_opcode OP_READ      = 4'd8;
    localparam t_opcode OP_BEFORE    = 4'd9;
    localparam t_opcode OP_AFTER     = 4'd10;

    // status codes
    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_BADPOS = 2'd1;
    localparam t_status ST_BADID  = 2'd2;
    localparam t_status ST_ABSENT = 2'd3;

    // command kinds broadcast along the cell row
    localparam t_cell_kind CK_HOLD  = 2'd0;
    localparam t_cell_kind CK_LOAD  = 2'd1;
    localparam t_cell_kind CK_SHIFT = 2'd2;

    // configuration register index (paddr[2])
    localparam logic REG_IDS_IN_USE = 1'b0;

    localparam t_ids_cfg IDS_RESET = 5'd16;

endpackage

`default_nettype wire

// ===== hdl/oidl_ifs.sv =====
// ordered id list engine: request and result channel interfaces
// valid/ready handshake with the payload fields of one transaction
// depends on oidl_pkg
`default_nettype none

interface oidl_req_if;
    logic                  valid;
    logic                  ready;
    oidl_pkg::t_opcode     opcode;
    oidl_pkg::t_item_id    item_id;
    oidl_pkg::t_first_pos  first_position;
    oidl_pkg::t_second_pos second_position;

    modport source (output valid, opcode, item_id, first_position, second_position,
                    input ready);
    modport sink   (input valid, opcode, item_id, first_position, second_position,
                    output ready);
endinterface

interface oidl_rsp_if;
    logic               valid;
    logic               ready;
    oidl_pkg::t_status  status;
    oidl_pkg::t_entry   entry_value;
    oidl_pkg::t_id_mask id_mask;
    oidl_pkg::t_length  list_length;

    modport source (output valid, status, entry_value, id_mask, list_length,
                    input ready);
    modport sink   (input valid, status, entry_value, id_mask, list_length,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/oidl_cell.sv =====
// ordered id list engine: one list slot
// takes its neighbor's value, a broadcast value or a load value per command
// depends on oidl_pkg; command struct comes in as a type parameter
`default_nettype none

module oidl_cell #(
    parameter int  MAX_IDS = 16,
    parameter int  IDX     = 0,
    parameter type t_cmd   = logic,
    localparam int SLOT_W  = $clog2(MAX_IDS),
    localparam int POS_W   = $clog2(MAX_IDS + 1)
) (
    input  wire logic              i_clk,
    input  wire t_cmd              i_cmd,
    input  wire logic [SLOT_W-1:0] i_left,
    input  wire logic [SLOT_W-1:0] i_right,
    output logic      [SLOT_W-1:0] o_slot
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;

    always_comb begin
        n_slot = r_slot;
        case (i_cmd.kind)
            oidl_pkg::CK_LOAD: begin
                if (MY_POS < i_cmd.dim) begin
                    n_slot = i_cmd.asc ? SLOT_W'(IDX)
                                       : SLOT_W'(i_cmd.dim - MY_POS - POS_W'(1));
                end
            end
            oidl_pkg::CK_SHIFT: begin
                if (MY_POS == i_cmd.pos) begin
                    n_slot = i_cmd.val;
                end else if (i_cmd.up && MY_POS > i_cmd.lo && MY_POS <= i_cmd.hi) begin
                    n_slot = i_left;
                end else if (!i_cmd.up && MY_POS >= i_cmd.lo && MY_POS < i_cmd.hi) begin
                    n_slot = i_right;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;

endmodule

`default_nettype wire

// ===== hdl/oidl_chain.sv =====
// ordered id list engine: row of slot cells with a single read port
// neighbors are linked both ways so a whole range can shift up or down at once
// depends on oidl_cell
`default_nettype none

module oidl_chain #(
    parameter int  MAX_IDS = 16,
    parameter type t_cmd   = logic,
    localparam int SLOT_W  = $clog2(MAX_IDS),
    localparam int POS_W   = $clog2(MAX_IDS + 1)
) (
    input  wire logic              i_clk,
    input  wire t_cmd              i_cmd,
    input  wire logic [POS_W-1:0]  i_rd_addr,
    output logic      [SLOT_W-1:0] o_rd_data
);

    // padded link array: ends tie to zero
    logic [SLOT_W-1:0] w_link [MAX_IDS + 2];

    assign w_link[0]           = '0;
    assign w_link[MAX_IDS + 1] = '0;

    for (genvar g = 0; g < MAX_IDS; g++) begin : g_cell
        oidl_cell #(
            .MAX_IDS (MAX_IDS),
            .IDX     (g),
            .t_cmd   (t_cmd)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (i_cmd),
            .i_left  (w_link[g]),
            .i_right (w_link[g + 2]),
            .o_slot  (w_link[g + 1])
        );
    end

    // and-or read select
    always_comb begin
        o_rd_data = '0;
        for (int g = 0; g < MAX_IDS; g++) begin
            o_rd_data = o_rd_data
                      | (w_link[g + 1] & {SLOT_W{i_rd_addr == POS_W'(g)}});
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ordered_id_list_engine_top.sv =====
// ordered id list engine: top level with sequencer and configuration port
// depends on oidl_pkg, oidl_ifs (oidl_req_if, oidl_rsp_if) and oidl_chain
//
// usage
//   i_req carries one request transaction (opcode, item_id, first_position,
//   second_position); o_rsp returns exactly one result transaction per request
//   (status, entry_value, id_mask, list_length). both are valid/ready channels.
//   the ids_in_use register sits at byte address 0 of the APB-style port;
//   the user must write it only while the engine is idle; the block does not enforce this.
// steps: every request passes a start and a finish state; clear, load, read,
//   unused opcodes and position errors need nothing more; move and exchange
//   read the second entry, and exchange then writes back the first position;
//   before, after, insert and fill scan the list; an insert whose id is
//   accepted then shifts it in, and fill walks the ids below the effective dimension
//   the list is held in a row of cells with one read port, so every scan of
//   the list reads one slot per cycle; a shift moves every cell of its range at once
// throughput: one request at a time; the next request is accepted in the
//   cycle after a result is loaded into the output register
// reset: list length returns to zero, ids_in_use to 16, no result pending;
//   slot contents are not cleared (only slots below the length are read)
// stall: a result waits in the output register; the engine still takes a new
//   request and finishes it, then holds that result until the register frees
`default_nettype none

module ordered_id_list_engine_top #(
    parameter int MAX_IDS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    oidl_req_if.sink         i_req,
    oidl_rsp_if.source       o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int SLOT_W = $clog2(MAX_IDS);
    localparam int POS_W  = $clog2(MAX_IDS + 1);

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_IDS);
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

    // command broadcast to every cell
    typedef struct packed {
        oidl_pkg::t_cell_kind kind;
        logic                 up;
        logic                 asc;
        logic [POS_W-1:0]     lo;
        logic [POS_W-1:0]     hi;
        logic [POS_W-1:0]     pos;
        logic [POS_W-1:0]     dim;
        logic [SLOT_W-1:0]    val;
    } t_cell_cmd;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_INS   = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_RDB   = 3'd5;
    localparam logic [2:0] S_WRB   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    // control registers
    logic [2:0]             r_state, n_state;
    logic [POS_W-1:0]       r_count, n_count;
    logic                   r_out_valid, n_out_valid;
    oidl_pkg::t_ids_cfg     r_ids;

    // working registers of the request in flight
    oidl_pkg::t_opcode      r_op, n_op;
    oidl_pkg::t_item_id     r_id, n_id;
    oidl_pkg::t_first_pos   r_p, n_p;
    oidl_pkg::t_second_pos  r_q, n_q;
    logic [POS_W-1:0]       r_dim, n_dim;
    logic [POS_W-1:0]       r_k, n_k;
    logic [POS_W-1:0]       r_n, n_n;
    logic [MAX_IDS-1:0]     r_have, n_have;
    logic                   r_found, n_found;
    logic [SLOT_W-1:0]      r_a, n_a;
    logic [SLOT_W-1:0]      r_b, n_b;
    oidl_pkg::t_status      r_status, n_status;
    oidl_pkg::t_entry       r_value, n_value;
    oidl_pkg::t_id_mask     r_mask, n_mask;

    // output register
    oidl_pkg::t_status      r_out_status, n_out_status;
    oidl_pkg::t_entry       r_out_value, n_out_value;
    oidl_pkg::t_id_mask     r_out_mask, n_out_mask;
    oidl_pkg::t_length      r_out_len, n_out_len;

    t_cell_cmd              w_cmd;
    logic [POS_W-1:0]       w_rd_addr;
    logic [SLOT_W-1:0]      w_rd;
    logic [POS_W-1:0]       w_dim;
    logic [MAX_IDS-1:0]     w_rd_bits;
    oidl_pkg::t_id_mask     w_rd_mask;
    logic                   w_rd_is_id;
    logic                   w_have_id;
    logic                   w_have_k;
    logic [POS_W-1:0]       w_fill_pos;
    logic                   w_cfg_wr;

    oidl_chain #(
        .MAX_IDS (MAX_IDS),
        .t_cmd   (t_cell_cmd)
    ) u_chain (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd)
    );

    // effective dimension: ids_in_use clamped to 1..MAX_IDS
    always_comb begin
        if (r_ids == '0) begin
            w_dim = POS_ONE;
        end else if (8'(r_ids) > 8'(MAX_IDS)) begin
            w_dim = POS_MAX;
        end else begin
            w_dim = POS_W'(r_ids);
        end
    end

    // decode of the slot being read and presence lookups
    always_comb begin
        w_have_id = 1'b0;
        w_have_k  = 1'b0;
        for (int j = 0; j < MAX_IDS; j++) begin
            w_rd_bits[j] = (8'(w_rd) == 8'(j));
            w_have_id    = w_have_id | (r_have[j] & (8'(r_id) == 8'(j)));
            w_have_k     = w_have_k  | (r_have[j] & (8'(r_k) == 8'(j)));
        end
        // ids of 16 and above never show in the mask
        for (int j = 0; j < 16; j++) begin
            w_rd_mask[j] = (8'(w_rd) == 8'(j));
        end
        w_rd_is_id = (8'(w_rd) == 8'(r_id));
    end

    // head fill inserts at the running count of added ids, tail at the end
    assign w_fill_pos = (r_op == oidl_pkg::OP_FILL_TAIL) ? r_count : r_n;

    assign i_req.ready = (r_state == S_IDLE);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_op         = r_op;
        n_id         = r_id;
        n_p          = r_p;
        n_q          = r_q;
        n_dim        = r_dim;
        n_k          = r_k;
        n_n          = r_n;
        n_have       = r_have;
        n_found      = r_found;
        n_a          = r_a;
        n_b          = r_b;
        n_status     = r_status;
        n_value      = r_value;
        n_mask       = r_mask;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_mask   = r_out_mask;
        n_out_len    = r_out_len;
        w_cmd        = '0;
        w_cmd.kind   = oidl_pkg::CK_HOLD;
        w_rd_addr    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op     = i_req.opcode;
                    n_id     = i_req.item_id;
                    n_p      = i_req.first_position;
                    n_q      = i_req.second_position;
                    n_dim    = w_dim;
                    n_status = oidl_pkg::ST_OK;
                    n_value  = '0;
                    n_mask   = '0;
                    n_have   = '0;
                    n_found  = 1'b0;
                    n_k      = '0;
                    n_n      = '0;
                    n_state  = S_START;
                end
            end

            S_START: begin
                unique case (r_op) inside
                    oidl_pkg::OP_CLEAR: begin
                        n_count = '0;
                        n_state = S_FIN;
                    end
                    oidl_pkg::OP_LOAD_ASC, oidl_pkg::OP_LOAD_DESC: begin
                        w_cmd.kind = oidl_pkg::CK_LOAD;
                        w_cmd.asc  = (r_op == oidl_pkg::OP_LOAD_ASC);
                        w_cmd.dim  = r_dim;
                        n_count    = r_dim;
                        n_state    = S_FIN;
                    end
                    oidl_pkg::OP_INSERT: begin
                        if (8'(r_p) > 8'(r_count)) begin
                            n_status = oidl_pkg::ST_BADPOS;
                            n_state  = S_FIN;
                        end else begin
                            n_state  = S_SCAN;
                        end
                    end
                    oidl_pkg::OP_MOVE, oidl_pkg::OP_EXCHANGE: begin
                        if (8'(r_p) >= 8'(r_count) || 8'(r_q) >= 8'(r_count)) begin
                            n_status = oidl_pkg::ST_BADPOS;
                            n_state  = S_FIN;
                        end else begin
                            w_rd_addr = POS_W'(r_p);
                            n_a       = w_rd;
                            n_state   = S_RDB;
                        end
                    end
                    oidl_pkg::OP_READ: begin
                        if (8'(r_p) >= 8'(r_count)) begin
                            n_status = oidl_pkg::ST_BADPOS;
                        end else begin
                            w_rd_addr = POS_W'(r_p);
                            n_value   = 4'(w_rd);
                        end
                        n_state = S_FIN;
                    end
                    oidl_pkg::OP_FILL_TAIL, oidl_pkg::OP_FILL_HEAD,
                    oidl_pkg::OP_BEFORE, oidl_pkg::OP_AFTER: begin
                        n_state = S_SCAN;
                    end
                    default: begin
                        // unused opcodes report ok and change nothing
                        n_state = S_FIN;
                    end
                endcase
            end

            S_SCAN: begin
                if (r_k < r_count) begin
                    // one slot per cycle: presence set, locate id, side masks
                    w_rd_addr = r_k;
                    n_have    = r_have | w_rd_bits;
                    if (w_rd_is_id) begin
                        n_found = 1'b1;
                    end
                    if (r_op == oidl_pkg::OP_BEFORE && !r_found && !w_rd_is_id) begin
                        n_mask = r_mask | w_rd_mask;
                    end
                    if (r_op == oidl_pkg::OP_AFTER && r_found) begin
                        n_mask = r_mask | w_rd_mask;
                    end
                    n_k = r_k + POS_ONE;
                end else begin
                    unique case (r_op) inside
                        oidl_pkg::OP_INSERT: begin
                            if (8'(r_id) >= 8'(r_dim) || w_have_id || r_count == POS_MAX) begin
                                n_status = oidl_pkg::ST_BADID;
                                n_state  = S_FIN;
                            end else begin
                                n_state  = S_INS;
                            end
                        end
                        oidl_pkg::OP_FILL_TAIL, oidl_pkg::OP_FILL_HEAD: begin
                            n_k     = '0;
                            n_state = S_FILL;
                        end
                        default: begin
                            if (!r_found) begin
                                n_status = oidl_pkg::ST_ABSENT;
                                n_mask   = '0;
                            end
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            S_INS: begin
                w_cmd.kind = oidl_pkg::CK_SHIFT;
                w_cmd.up   = 1'b1;
                w_cmd.lo   = POS_W'(r_p);
                w_cmd.hi   = r_count;
                w_cmd.pos  = POS_W'(r_p);
                w_cmd.val  = SLOT_W'(r_id);
                n_count    = r_count + POS_ONE;
                n_state    = S_FIN;
            end

            S_FILL: begin
                // walk candidate ids ascending, one per cycle
                if (r_k < r_dim) begin
                    if (!w_have_k && r_count < POS_MAX) begin
                        w_cmd.kind = oidl_pkg::CK_SHIFT;
                        w_cmd.up   = 1'b1;
                        w_cmd.lo   = w_fill_pos;
                        w_cmd.hi   = r_count;
                        w_cmd.pos  = w_fill_pos;
                        w_cmd.val  = SLOT_W'(r_k);
                        n_count    = r_count + POS_ONE;
                        n_n        = r_n + POS_ONE;
                    end
                    n_k = r_k + POS_ONE;
                end else begin
                    n_state = S_FIN;
                end
            end

            S_RDB: begin
                w_rd_addr  = POS_W'(r_q);
                w_cmd.kind = oidl_pkg::CK_SHIFT;
                w_cmd.pos  = POS_W'(r_q);
                w_cmd.val  = r_a;
                if (r_op == oidl_pkg::OP_MOVE) begin
                    if (8'(r_p) < 8'(r_q)) begin
                        w_cmd.up = 1'b0;
                        w_cmd.lo = POS_W'(r_p);
                        w_cmd.hi = POS_W'(r_q);
                    end else begin
                        w_cmd.up = 1'b1;
                        w_cmd.lo = POS_W'(r_q);
                        w_cmd.hi = POS_W'(r_p);
                    end
                    n_state = S_FIN;
                end else begin
                    // exchange: capture the second entry before it is overwritten
                    w_cmd.up = 1'b1;
                    w_cmd.lo = POS_W'(r_q);
                    w_cmd.hi = POS_W'(r_q);
                    n_b      = w_rd;
                    n_state  = S_WRB;
                end
            end

            S_WRB: begin
                w_cmd.kind = oidl_pkg::CK_SHIFT;
                w_cmd.up   = 1'b1;
                w_cmd.lo   = POS_W'(r_p);
                w_cmd.hi   = POS_W'(r_p);
                w_cmd.pos  = POS_W'(r_p);
                w_cmd.val  = r_b;
                n_state    = S_FIN;
            end

            S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_value  = r_value;
                    n_out_mask   = r_mask;
                    n_out_len    = 5'(r_count);
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == oidl_pkg::REG_IDS_IN_USE);

    always_comb begin
        unique case (paddr[2])
            oidl_pkg::REG_IDS_IN_USE: prdata = 32'(r_ids);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_ids       <= oidl_pkg::IDS_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                r_ids <= pwdata[4:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_id         <= n_id;
        r_p          <= n_p;
        r_q          <= n_q;
        r_dim        <= n_dim;
        r_k          <= n_k;
        r_n          <= n_n;
        r_have       <= n_have;
        r_found      <= n_found;
        r_a          <= n_a;
        r_b          <= n_b;
        r_status     <= n_status;
        r_value      <= n_value;
        r_mask       <= n_mask;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_mask   <= n_out_mask;
        r_out_len    <= n_out_len;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_value = r_out_value;
    assign o_rsp.id_mask     = r_out_mask;
    assign o_rsp.list_length = r_out_len;

    // list never grows past the slot row
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= POS_MAX)
        else $error("list length beyond slot count");

    // scan pointer stays within the list
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k <= r_count))
        else $error("scan pointer past list length");

    // an accepted request always starts decoding next
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_START))
        else $error("accepted request not started");

    // a result only appears out of the finish step
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result raised outside finish step");

endmodule

`default_nettype wire

// ===== tb/ordered_id_list_engine_top_test.sv =====
// testbench for ordered_id_list_engine_top: drives list requests, predicts every result
// with its own list model and checks each result transaction field by field
// depends on oidl_pkg, oidl_ifs (oidl_req_if, oidl_rsp_if) and the engine top level
`default_nettype none

module ordered_id_list_engine_top_test;
    import oidl_pkg::*;

    localparam int MAX_IDS     = 16;
    localparam int IDLE_MAX    = 17;
    localparam int PHASE_ITEMS = 172;
    localparam int DRAIN_WAIT  = 40;       // longest latency is a fill on a full list
    localparam int OPCODE_TOP  = 2 ** $bits(t_opcode) - 1;

    // one request and one result as the testbench keeps them
    typedef struct packed {
        t_opcode     opcode;
        t_item_id    item_id;
        t_first_pos  first_position;
        t_second_pos second_position;
    } t_list_req;

    typedef struct packed {
        t_status  status;
        t_entry   entry_value;
        t_id_mask id_mask;
        t_length  list_length;
    } t_list_rsp;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    oidl_req_if req_ch ();
    oidl_rsp_if rsp_ch ();

    ordered_id_list_engine_top #(
        .MAX_IDS (MAX_IDS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // requests waiting for the driver, results waiting for the monitor
    t_list_req queued_requests [$];
    t_list_rsp predicted_results [$];

    // shadow of the engine: list slots, length and the ids_in_use register
    t_entry   list_slots [MAX_IDS];
    int       list_count;
    t_ids_cfg ids_in_use_cfg;

    // bookkeeping for the summary
    int fail_count;
    int accepted_count;
    int settings_count;
    int status_seen [4];
    bit burst_mode;

    int ids_plan [9] = '{16, 1, 31, 0, 9, 16, 4, 13, 2};

    // ------------------------------------------------------------------
    // clock and the single reset at the start of the run
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n                = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        req_ch.valid           = 1'b0;
        req_ch.opcode          = OP_CLEAR;
        req_ch.item_id         = '0;
        req_ch.first_position  = '0;
        req_ch.second_position = '0;
        rsp_ch.ready           = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // list model
    // ------------------------------------------------------------------

    // ids_in_use clamped to 1..MAX_IDS
    function automatic int effective_dim();
        if (ids_in_use_cfg == 0) begin
            return 1;
        end
        if (ids_in_use_cfg > MAX_IDS) begin
            return MAX_IDS;
        end
        return int'(ids_in_use_cfg);
    endfunction

    // applies one request to the shadow list and returns the result it must produce
    function automatic t_list_rsp predict_list_update(t_list_req rq);
        t_list_rsp   res;
        int          dim, len, p, q, at, n, i;
        logic [15:0] have;
        t_entry      held;
        t_entry      missing [MAX_IDS];
        dim  = effective_dim();
        len  = list_count;
        p    = int'(rq.first_position);
        q    = int'(rq.second_position);
        res  = '0;
        have = '0;
        at   = -1;
        n    = 0;
        // ids present and where item_id sits, from the list as it stands
        for (i = 0; i < list_count; i++) begin
            have[list_slots[i]] = 1'b1;
            if (list_slots[i] == rq.item_id && at < 0) begin
                at = i;
            end
        end
        case (rq.opcode)
            OP_CLEAR: begin
                len = 0;
            end
            OP_LOAD_ASC, OP_LOAD_DESC: begin
                for (i = 0; i < dim; i++) begin
                    list_slots[i] = t_entry'((rq.opcode == OP_LOAD_ASC) ? i : dim - 1 - i);
                end
                len = dim;
            end
            OP_INSERT: begin
                // position is checked ahead of the id
                if (p > len) begin
                    res.status = ST_BADPOS;
                end else if (rq.item_id >= dim || have[rq.item_id] || len >= MAX_IDS) begin
                    res.status = ST_BADID;
                end else begin
                    for (i = len; i > p; i--) begin
                        list_slots[i] = list_slots[i - 1];
                    end
                    list_slots[p] = rq.item_id;
                    len++;
                end
            end
            OP_MOVE: begin
                if (p >= len || q >= len) begin
                    res.status = ST_BADPOS;
                end else begin
                    held = list_slots[p];
                    if (p < q) begin
                        for (i = p; i < q; i++) begin
                            list_slots[i] = list_slots[i + 1];
                        end
                    end else begin
                        for (i = p; i > q; i--) begin
                            list_slots[i] = list_slots[i - 1];
                        end
                    end
                    list_slots[q] = held;
                end
            end
            OP_EXCHANGE: begin
                if (p >= len || q >= len) begin
                    res.status = ST_BADPOS;
                end else begin
                    held          = list_slots[p];
                    list_slots[p] = list_slots[q];
                    list_slots[q] = held;
                end
            end
            OP_FILL_TAIL, OP_FILL_HEAD: begin
                // only ids below the current dimension that are missing
                for (i = 0; i < dim; i++) begin
                    if (!have[i] && n + len < MAX_IDS) begin
                        missing[n] = t_entry'(i);
                        n++;
                    end
                end
                if (rq.opcode == OP_FILL_TAIL) begin
                    for (i = 0; i < n; i++) begin
                        list_slots[len + i] = missing[i];
                    end
                end else begin
                    for (i = len; i > 0; i--) begin
                        list_slots[i - 1 + n] = list_slots[i - 1];
                    end
                    for (i = 0; i < n; i++) begin
                        list_slots[i] = missing[i];
                    end
                end
                len += n;
            end
            OP_READ: begin
                if (p >= len) begin
                    res.status = ST_BADPOS;
                end else begin
                    res.entry_value = list_slots[p];
                end
            end
            OP_BEFORE, OP_AFTER: begin
                if (at < 0) begin
                    res.status = ST_ABSENT;
                end else if (rq.opcode == OP_BEFORE) begin
                    for (i = 0; i < at; i++) begin
                        res.id_mask[list_slots[i]] = 1'b1;
                    end
                end else begin
                    for (i = at + 1; i < len; i++) begin
                        res.id_mask[list_slots[i]] = 1'b1;
                    end
                end
            end
            default: begin
                // unused opcodes leave everything as it is
            end
        endcase
        list_count      = len;
        res.list_length = t_length'(len);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // wait before the next transaction on either side; zero in burst stretches
    function automatic int idle_cycles();
        return burst_mode ? 0 : int'($urandom_range(0, IDLE_MAX));
    endfunction

    task automatic queue_request(input t_opcode op, input int id, input int p, input int q);
        t_list_req rq;
        rq.opcode          = op;
        rq.item_id         = t_item_id'(id);
        rq.first_position  = t_first_pos'(p);
        rq.second_position = t_second_pos'(q);
        queued_requests.push_back(rq);
    endtask

    // mostly well-formed requests aimed at the list as it stands (the model lags
    // by the one request still in flight), the rest unconstrained noise
    function automatic t_list_req random_request();
        t_list_req   rq;
        int          dim, len, pick, i, n;
        logic [15:0] have;
        int          absent_ids [MAX_IDS];
        dim  = effective_dim();
        len  = list_count;
        have = '0;
        n    = 0;
        for (i = 0; i < len; i++) begin
            have[list_slots[i]] = 1'b1;
        end
        for (i = 0; i < dim; i++) begin
            if (!have[i]) begin
                absent_ids[n] = i;
                n++;
            end
        end
        rq.opcode          = t_opcode'($urandom);
        rq.item_id         = t_item_id'($urandom);
        rq.first_position  = t_first_pos'($urandom);
        rq.second_position = t_second_pos'($urandom);
        pick = int'($urandom_range(0, 99));
        if (pick < 3) begin
            rq.opcode = OP_CLEAR;
        end else if (pick < 6) begin
            rq.opcode = OP_LOAD_ASC;
        end else if (pick < 9) begin
            rq.opcode = OP_LOAD_DESC;
        end else if (pick < 33) begin
            rq.opcode = OP_INSERT;
        end else if (pick < 45) begin
            rq.opcode = OP_MOVE;
        end else if (pick < 55) begin
            rq.opcode = OP_EXCHANGE;
        end else if (pick < 59) begin
            rq.opcode = OP_FILL_TAIL;
        end else if (pick < 63) begin
            rq.opcode = OP_FILL_HEAD;
        end else if (pick < 74) begin
            rq.opcode = OP_READ;
        end else if (pick < 84) begin
            rq.opcode = OP_BEFORE;
        end else if (pick < 94) begin
            rq.opcode = OP_AFTER;
        end else if (pick < 97) begin
            rq.opcode = t_opcode'($urandom_range(int'(OP_AFTER) + 1, OPCODE_TOP));
        end
        // shape positions and ids for most requests that carry a legal opcode
        if (pick < 94 && $urandom_range(0, 99) < 85) begin
            if (rq.opcode == OP_INSERT) begin
                rq.first_position = t_first_pos'($urandom_range(0, len));
            end else begin
                rq.first_position = t_first_pos'($urandom_range(0, len > 0 ? len - 1 : 0));
            end
            rq.second_position = t_second_pos'($urandom_range(0, len > 0 ? len - 1 : 0));
            if ((rq.opcode == OP_BEFORE || rq.opcode == OP_AFTER) && len > 0) begin
                rq.item_id = list_slots[$urandom_range(0, len - 1)];
            end else if (rq.opcode == OP_INSERT && n > 0 && $urandom_range(0, 3) != 0) begin
                rq.item_id = t_item_id'(absent_ids[$urandom_range(0, n - 1)]);
            end else begin
                rq.item_id = t_item_id'($urandom_range(0, dim - 1));
            end
        end
        return rq;
    endfunction

    // apb write of ids_in_use: setup cycle, access cycle, written on the edge
    // that sees psel, penable, pwrite and pready together
    task automatic write_ids_in_use(input int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_IDS_IN_USE, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ids_in_use_cfg = t_ids_cfg'(value);
        settings_count++;
    endtask

    // engine idle: nothing queued, nothing offered, no result outstanding
    task automatic wait_for_idle();
        while (queued_requests.size() != 0 || req_ch.valid || predicted_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // request driver: offers queued transactions, predicts each accepted one
    // ------------------------------------------------------------------
    int gap_left;

    always @(posedge i_clk) begin : request_driver
        t_list_req taken;
        t_list_req next_req;
        if (!i_rst_n) begin
            req_ch.valid           <= 1'b0;
            req_ch.opcode          <= OP_CLEAR;
            req_ch.item_id         <= '0;
            req_ch.first_position  <= '0;
            req_ch.second_position <= '0;
            gap_left               <= 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                taken.opcode          = req_ch.opcode;
                taken.item_id         = req_ch.item_id;
                taken.first_position  = req_ch.first_position;
                taken.second_position = req_ch.second_position;
                predicted_results.push_back(predict_list_update(taken));
                accepted_count++;
            end
            // a new transaction only once the current one is gone
            if (!req_ch.valid || req_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left     <= gap_left - 1;
                    req_ch.valid <= 1'b0;
                end else if (queued_requests.size() != 0) begin
                    next_req                = queued_requests.pop_front();
                    req_ch.valid           <= 1'b1;
                    req_ch.opcode          <= next_req.opcode;
                    req_ch.item_id         <= next_req.item_id;
                    req_ch.first_position  <= next_req.first_position;
                    req_ch.second_position <= next_req.second_position;
                    gap_left               <= idle_cycles();
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: random back-pressure, compares against the oldest prediction
    // ------------------------------------------------------------------
    int stall_left;

    always @(posedge i_clk) begin : result_monitor
        t_list_rsp got;
        t_list_rsp want;
        int        draw;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.status      = rsp_ch.status;
                got.entry_value = rsp_ch.entry_value;
                got.id_mask     = rsp_ch.id_mask;
                got.list_length = rsp_ch.list_length;
                status_seen[got.status]++;
                if (predicted_results.size() == 0) begin
                    $error("result transaction with no request outstanding: status %0d length %0d",
                           got.status, got.list_length);
                    fail_count++;
                end else begin
                    want = predicted_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        fail_count++;
                    end
                    if (got.entry_value !== want.entry_value) begin
                        $error("entry_value mismatch: expected %0d, actual %0d",
                               want.entry_value, got.entry_value);
                        fail_count++;
                    end
                    if (got.id_mask !== want.id_mask) begin
                        $error("id_mask mismatch: expected 0x%04h, actual 0x%04h",
                               want.id_mask, got.id_mask);
                        fail_count++;
                    end
                    if (got.list_length !== want.list_length) begin
                        $error("list_length mismatch: expected %0d, actual %0d",
                               want.list_length, got.list_length);
                        fail_count++;
                    end
                end
                draw = idle_cycles();
                stall_left   <= draw;
                rsp_ch.ready <= (draw == 0);
            end else if (stall_left > 0) begin
                stall_left   <= stall_left - 1;
                rsp_ch.ready <= (stall_left == 1);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus: directed opening, then random phases under several settings
    // ------------------------------------------------------------------
    initial begin : stimulus
        int ph;
        int k;
        fail_count     = 0;
        accepted_count = 0;
        settings_count = 0;
        burst_mode     = 1'b0;
        list_count     = 0;
        ids_in_use_cfg = IDS_RESET;
        for (k = 0; k < MAX_IDS; k++) begin
            list_slots[k] = '0;
        end
        for (k = 0; k < 4; k++) begin
            status_seen[k] = 0;
        end
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);

        for (ph = 0; ph < $size(ids_plan); ph++) begin
            if (ph > 0) begin
                wait_for_idle();
            end
            write_ids_in_use(ids_plan[ph]);
            @(negedge i_clk);

            if (ph == 0) begin
                // empty list: every position is out of range, every id absent
                queue_request(OP_READ, 0, 0, 0);
                queue_request(OP_BEFORE, 0, 0, 0);
                // fill on an empty list, then a full list rejects any insert
                queue_request(OP_FILL_TAIL, 0, 0, 0);
                queue_request(OP_INSERT, 3, 16, 0);
                queue_request(OP_INSERT, 3, 17, 0);     // bad position wins over bad id
                queue_request(OP_READ, 0, 15, 0);
                queue_request(OP_READ, 0, 16, 0);
                queue_request(OP_AFTER, 0, 0, 0);
                queue_request(OP_BEFORE, 15, 0, 0);
                // moves and exchanges across the whole list, equal positions too
                queue_request(OP_MOVE, 0, 0, 15);
                queue_request(OP_MOVE, 0, 15, 0);
                queue_request(OP_MOVE, 0, 5, 5);
                queue_request(OP_EXCHANGE, 0, 0, 15);
                queue_request(OP_MOVE, 0, 31, 0);
                queue_request(OP_LOAD_DESC, 0, 0, 0);
                queue_request(OP_READ, 0, 0, 0);
                queue_request(OP_CLEAR, 0, 0, 0);
                queue_request(OP_EXCHANGE, 0, 0, 0);
                // insert at head of an empty list, duplicate, tail, head, middle
                queue_request(OP_INSERT, 7, 0, 0);
                queue_request(OP_INSERT, 7, 1, 0);
                queue_request(OP_INSERT, 2, 1, 0);
                queue_request(OP_INSERT, 9, 0, 0);
                queue_request(OP_INSERT, 4, 1, 0);
                queue_request(OP_FILL_HEAD, 0, 0, 0);
                queue_request(OP_AFTER, 15, 0, 15);
                queue_request(t_opcode'(OPCODE_TOP), 15, 31, 15);
                queue_request(OP_LOAD_ASC, 0, 0, 0);
            end

            // random part; the model is read once the previous request left the queue
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 50 == 0) begin
                    burst_mode = ($urandom_range(0, 3) == 0);
                end
                while (queued_requests.size() != 0) begin
                    @(negedge i_clk);
                end
                queued_requests.push_back(random_request());
            end
            burst_mode = 1'b0;
        end

        // drain, then leave room for any stray result
        wait_for_idle();
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("checked %0d request transactions over %0d ids_in_use settings",
                 accepted_count, settings_count);
        $display("statuses seen: ok %0d, bad position %0d, bad id %0d, absent %0d",
                 status_seen[ST_OK], status_seen[ST_BADPOS], status_seen[ST_BADID],
                 status_seen[ST_ABSENT]);
        if (fail_count == 0 && predicted_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog far beyond the slowest correct run
    initial begin : watchdog
        #(10 * 1_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
